// File: rtl/pcdm_pkg.sv
// Shared constants, types and codes for the path crossover merge block.
package pcdm_pkg;

    // Store geometry.
    localparam int MAX_LEN   = 32;
    localparam int NODE_BITS = 16;
    localparam int IDX_W     = $clog2(MAX_LEN);
    localparam int CNT_W     = $clog2(MAX_LEN + 1);

    // Position registers must hold the counts and the 6-bit cut of the second sequence.
    localparam int POS_W     = (CNT_W > 6) ? CNT_W : 6;

    // Transaction kinds.
    localparam logic [1:0] KIND_FIRST  = 2'd0;
    localparam logic [1:0] KIND_SECOND = 2'd1;
    localparam logic [1:0] KIND_MERGE  = 2'd2;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_ERR,
        S_SCAN,
        S_EMIT_A,
        S_SUFFIX
    } t_state;

    // Request from the sequencer to one store.
    typedef struct packed {
        logic                 we;
        logic [IDX_W-1:0]     waddr;
        logic [NODE_BITS-1:0] wdata;
        logic [IDX_W-1:0]     raddr;
    } t_ram_req;

endpackage

// File: rtl/pcdm_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module pcdm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/pcdm_ctrl.sv
// Sequencer: loads the stores, walks the compare loop and drives the result register.
module pcdm_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [1:0]                    i_kind,
    input  logic [15:0]                   i_node,
    input  logic [4:0]                    i_cut_first,
    input  logic [5:0]                    i_cut_second,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [15:0]                   o_node_out,
    output logic                          o_last,
    output logic                          o_error,
    output pcdm_pkg::t_ram_req            o_req_a,
    output pcdm_pkg::t_ram_req            o_req_b,
    input  logic [pcdm_pkg::NODE_BITS-1:0] i_rd_a,
    input  logic [pcdm_pkg::NODE_BITS-1:0] i_rd_b
);
    import pcdm_pkg::*;

    t_state               r_state, n_state;
    logic [CNT_W-1:0]     r_cnt_a, n_cnt_a;
    logic [CNT_W-1:0]     r_cnt_b, n_cnt_b;
    logic [POS_W-1:0]     r_i, n_i;
    logic [POS_W-1:0]     r_j, n_j;
    logic [POS_W-1:0]     r_cut1, n_cut1;
    logic [POS_W-1:0]     r_start2, n_start2;
    logic [POS_W-1:0]     r_cnt2, n_cnt2;
    logic                 r_out_valid, n_out_valid;
    logic [NODE_BITS-1:0] r_out_node, n_out_node;
    logic                 r_out_last, n_out_last;
    logic                 r_out_err, n_out_err;
    logic                 out_free;
    logic                 suffix_empty;
    logic                 prefix_end;
    logic                 suffix_end;

    // Control state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt_a     <= '0;
            r_cnt_b     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt_a     <= n_cnt_a;
            r_cnt_b     <= n_cnt_b;
            r_out_valid <= n_out_valid;
        end
    end

    // Positions and result payload.
    always_ff @(posedge i_clk) begin
        r_i        <= n_i;
        r_j        <= n_j;
        r_cut1     <= n_cut1;
        r_start2   <= n_start2;
        r_cnt2     <= n_cnt2;
        r_out_node <= n_out_node;
        r_out_last <= n_out_last;
        r_out_err  <= n_out_err;
    end

    assign out_free     = !r_out_valid || !i_out_stall;
    assign suffix_empty = (r_start2 == r_cnt2);
    assign prefix_end   = (r_i == r_cut1);
    assign suffix_end   = (POS_W'(r_j + 1'b1) == r_cnt2);

    // Next state, store requests and result loading.
    always_comb begin
        n_state     = r_state;
        n_cnt_a     = r_cnt_a;
        n_cnt_b     = r_cnt_b;
        n_i         = r_i;
        n_j         = r_j;
        n_cut1      = r_cut1;
        n_start2    = r_start2;
        n_cnt2      = r_cnt2;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_node  = r_out_node;
        n_out_last  = r_out_last;
        n_out_err   = r_out_err;

        o_req_a       = '0;
        o_req_b       = '0;
        o_req_a.waddr = r_cnt_a[IDX_W-1:0];
        o_req_a.wdata = NODE_BITS'(i_node);
        o_req_b.waddr = r_cnt_b[IDX_W-1:0];
        o_req_b.wdata = NODE_BITS'(i_node);

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    case (i_kind)
                        KIND_FIRST: begin
                            // Append unless the store is full.
                            if (r_cnt_a != CNT_W'(MAX_LEN)) begin
                                o_req_a.we = 1'b1;
                                n_cnt_a    = CNT_W'(r_cnt_a + 1'b1);
                            end
                        end
                        KIND_SECOND: begin
                            if (r_cnt_b != CNT_W'(MAX_LEN)) begin
                                o_req_b.we = 1'b1;
                                n_cnt_b    = CNT_W'(r_cnt_b + 1'b1);
                            end
                        end
                        KIND_MERGE: begin
                            // Capture the cuts and the second length, then empty both stores.
                            n_cut1   = POS_W'(i_cut_first);
                            n_start2 = POS_W'(i_cut_second);
                            n_cnt2   = POS_W'(r_cnt_b);
                            n_i      = '0;
                            n_j      = POS_W'(i_cut_second);
                            n_cnt_a  = '0;
                            n_cnt_b  = '0;
                            if ((POS_W'(i_cut_first) >= POS_W'(r_cnt_a)) ||
                                (POS_W'(i_cut_second) > POS_W'(r_cnt_b))) begin
                                n_state = S_ERR;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_ERR: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_node  = '0;
                    n_out_last  = 1'b1;
                    n_out_err   = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_SCAN: begin
                // One compare of a prefix element against one suffix element per cycle.
                if (r_j == r_cnt2) begin
                    n_state = S_EMIT_A;
                end else if (i_rd_a == i_rd_b) begin
                    n_j = r_start2;
                    if (prefix_end) begin
                        n_state = S_SUFFIX;
                    end else begin
                        n_i = POS_W'(r_i + 1'b1);
                    end
                end else begin
                    n_j = POS_W'(r_j + 1'b1);
                end
            end
            S_EMIT_A: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_node  = i_rd_a;
                    n_out_last  = prefix_end && suffix_empty;
                    n_out_err   = 1'b0;
                    n_j         = r_start2;
                    if (prefix_end) begin
                        n_state = suffix_empty ? S_IDLE : S_SUFFIX;
                    end else begin
                        n_i     = POS_W'(r_i + 1'b1);
                        n_state = S_SCAN;
                    end
                end
            end
            S_SUFFIX: begin
                // Copy the suffix of the second sequence, one element per cycle while the output is not stalled.
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_node  = i_rd_b;
                    n_out_last  = suffix_end;
                    n_out_err   = 1'b0;
                    if (suffix_end) begin
                        n_state = S_IDLE;
                    end else begin
                        n_j = POS_W'(r_j + 1'b1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Read addresses follow the next positions so data lines up with the registers.
        o_req_a.raddr = n_i[IDX_W-1:0];
        o_req_b.raddr = n_j[IDX_W-1:0];
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_node_out  = 16'(r_out_node);
    assign o_last      = r_out_last;
    assign o_error     = r_out_err;

endmodule

// File: rtl/path_crossover_dedup_merge_top.sv
// Top level of the path crossover merge with duplicate removal.
// Load transactions are accepted back to back.
// A merge compares each prefix element against the suffix in the shared compare loop,
// emits it unless it matched, and then copies each suffix element.
// An invalid cut gives its single error result through the error state.
// Synchronous active-low reset empties both stores and the result register; no clearing pass.
module path_crossover_dedup_merge_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_kind,
    input  logic [15:0] i_node,
    input  logic [4:0]  i_cut_first,
    input  logic [5:0]  i_cut_second,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_node_out,
    output logic        o_last,
    output logic        o_error
);
    import pcdm_pkg::*;

    t_ram_req             req_a;
    t_ram_req             req_b;
    logic [NODE_BITS-1:0] rd_a;
    logic [NODE_BITS-1:0] rd_b;

    // Store of the first sequence.
    pcdm_ram #(
        .WIDTH (NODE_BITS),
        .DEPTH (MAX_LEN)
    ) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (req_a.we),
        .i_waddr (req_a.waddr),
        .i_wdata (req_a.wdata),
        .i_raddr (req_a.raddr),
        .o_rdata (rd_a)
    );

    // Store of the second sequence.
    pcdm_ram #(
        .WIDTH (NODE_BITS),
        .DEPTH (MAX_LEN)
    ) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (req_b.we),
        .i_waddr (req_b.waddr),
        .i_wdata (req_b.wdata),
        .i_raddr (req_b.raddr),
        .o_rdata (rd_b)
    );

    // Sequencer and result register.
    pcdm_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_kind       (i_kind),
        .i_node       (i_node),
        .i_cut_first  (i_cut_first),
        .i_cut_second (i_cut_second),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_node_out   (o_node_out),
        .o_last       (o_last),
        .o_error      (o_error),
        .o_req_a      (req_a),
        .o_req_b      (req_b),
        .i_rd_a       (rd_a),
        .i_rd_b       (rd_b)
    );

    // An error result is always the closing result and carries no node.
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_error) |-> (o_last && (o_node_out == 16'd0)))
        else $error("error result without last or with a node");

    // A merge transaction blocks further input on the following cycle.
    a_merge_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && (i_kind == KIND_MERGE)) |=> o_in_stall)
        else $error("input not stalled after a merge transaction");

    // One load transaction never writes both stores.
    a_one_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(req_a.we && req_b.we))
        else $error("both stores written in one cycle");

    // Stores are written only while input is being taken.
    a_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (req_a.we || req_b.we) |-> (i_in_valid && !o_in_stall))
        else $error("store written outside a load transaction");

endmodule

// File: dv/path_crossover_dedup_merge_top_test.sv
// Self-checking testbench for the path crossover merge with duplicate removal.
module path_crossover_dedup_merge_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import pcdm_pkg::*;

    // Kind code that the block must ignore.
    localparam logic [1:0] KIND_NONE = 2'd3;

    localparam int DIR_ROWS     = 26;
    localparam int TARGET_ITEMS = 330;
    // Idle time after the final drain, so that any tail of output is covered.
    localparam int DRAIN_CYCLES = 1200;

    // One merged node as it leaves the block.
    typedef struct packed {
        logic [15:0] node;
        logic        last;
        logic        err;
    } t_path_node;

    // One row of the directed stimulus table.
    typedef struct {
        logic [1:0]  kind;
        logic [15:0] node;
        logic [4:0]  cf;
        logic [5:0]  cs;
        bit          typed;
        t_path_node  res;
    } t_dir_row;

    // How the cuts of a random merge are chosen.
    typedef enum {
        CUT_LEGAL,
        CUT_ANY,
        CUT_EDGE,
        CUT_WIDE
    } t_cut_mode;

    localparam t_path_node ERR_RES  = '{16'h0000, 1'b1, 1'b1};
    localparam t_path_node NONE_RES = '{16'h0000, 1'b0, 1'b0};

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_in_valid   = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_kind       = KIND_FIRST;
    logic [15:0] i_node       = '0;
    logic [4:0]  i_cut_first  = '0;
    logic [5:0]  i_cut_second = '0;
    logic        o_out_valid;
    logic        i_out_stall  = 1'b0;
    logic [15:0] o_node_out;
    logic        o_last;
    logic        o_error;

    // Predictor state: its own copy of both stores and counts.
    logic [NODE_BITS-1:0] path_a [MAX_LEN];
    logic [NODE_BITS-1:0] path_b [MAX_LEN];
    int                   len_a_st;
    int                   len_b_st;
    t_path_node           merged_path_q [$];

    int fail_cnt    = 0;
    int items_sent  = 0;
    int merges      = 0;
    int bad_cuts    = 0;
    int dropped     = 0;
    int nodes_seen  = 0;
    bit quiet       = 1'b0;

    t_dir_row dir_tab [DIR_ROWS] = '{
        '{KIND_MERGE,  16'h0000, 5'd0,  6'd0,  1'b1, ERR_RES},
        '{KIND_NONE,   16'hFFFF, 5'd31, 6'd63, 1'b0, NONE_RES},
        '{KIND_FIRST,  16'hFFFF, 5'd0,  6'd0,  1'b0, NONE_RES},
        '{KIND_MERGE,  16'h0000, 5'd0,  6'd0,  1'b1, '{16'hFFFF, 1'b1, 1'b0}},
        '{KIND_FIRST,  16'h0000, 5'd0,  6'd0,  1'b0, NONE_RES},
        '{KIND_MERGE,  16'h0000, 5'd0,  6'd32, 1'b1, ERR_RES},
        '{KIND_FIRST,  16'h0001, 5'd0,  6'd0,  1'b0, NONE_RES},
        '{KIND_FIRST,  16'h0002, 5'd0,  6'd0,  1'b0, NONE_RES},
        '{KIND_FIRST,  16'h0003, 5'd0,  6'd0,  1'b0, NONE_RES},
        '{KIND_SECOND, 16'h0002, 5'd0,  6'd0,  1'b0, NONE_RES},
        '{KIND_SECOND, 16'h0009, 5'd0,  6'd0,  1'b0, NONE_RES},
        '{KIND_MERGE,  16'h5A5A, 5'd2,  6'd0,  1'b0, NONE_RES},
        '{KIND_FIRST,  16'h0005, 5'd0,  6'd0,  1'b0, NONE_RES},
        '{KIND_SECOND, 16'h0005, 5'd0,  6'd0,  1'b0, NONE_RES},
        '{KIND_MERGE,  16'h0000, 5'd0,  6'd0,  1'b0, NONE_RES},
        '{KIND_FIRST,  16'h0007, 5'd0,  6'd0,  1'b0, NONE_RES},
        '{KIND_SECOND, 16'h0008, 5'd0,  6'd0,  1'b0, NONE_RES},
        '{KIND_MERGE,  16'h0000, 5'd0,  6'd1,  1'b0, NONE_RES},
        '{KIND_FIRST,  16'h1234, 5'd0,  6'd0,  1'b0, NONE_RES},
        '{KIND_MERGE,  16'h0000, 5'd31, 6'd0,  1'b1, ERR_RES},
        '{KIND_SECOND, 16'h00AA, 5'd0,  6'd0,  1'b0, NONE_RES},
        '{KIND_MERGE,  16'h0000, 5'd0,  6'd0,  1'b1, ERR_RES},
        '{KIND_FIRST,  16'h8000, 5'd0,  6'd0,  1'b0, NONE_RES},
        '{KIND_SECOND, 16'h8000, 5'd0,  6'd0,  1'b0, NONE_RES},
        '{KIND_SECOND, 16'h7FFF, 5'd0,  6'd0,  1'b0, NONE_RES},
        '{KIND_MERGE,  16'hFFFF, 5'd0,  6'd1,  1'b0, NONE_RES}
    };

    path_crossover_dedup_merge_top u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_kind       (i_kind),
        .i_node       (i_node),
        .i_cut_first  (i_cut_first),
        .i_cut_second (i_cut_second),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_node_out   (o_node_out),
        .o_last       (o_last),
        .o_error      (o_error)
    );

    // Clock with an 8 ns period.
    always #4 i_clk = ~i_clk;

    // Predict the merged nodes caused by one accepted transaction.
    task automatic predict_crossover(input logic [1:0] kind, input logic [15:0] node,
                                     input logic [4:0] cf, input logic [5:0] cs);
        int         i;
        int         j;
        int         n0;
        bit         dup;
        t_path_node r;
        n0 = merged_path_q.size();
        case (kind)
            KIND_FIRST: begin
                if (len_a_st < MAX_LEN) begin
                    path_a[len_a_st] = node[NODE_BITS-1:0];
                    len_a_st++;
                end else begin
                    dropped++;
                end
            end
            KIND_SECOND: begin
                if (len_b_st < MAX_LEN) begin
                    path_b[len_b_st] = node[NODE_BITS-1:0];
                    len_b_st++;
                end else begin
                    dropped++;
                end
            end
            KIND_MERGE: begin
                merges++;
                if (int'(cf) >= len_a_st || int'(cs) > len_b_st) begin
                    bad_cuts++;
                    merged_path_q.push_back(ERR_RES);
                end else begin
                    // Prefix of the first path, minus nodes found in the kept suffix.
                    for (i = 0; i <= int'(cf); i++) begin
                        dup = 1'b0;
                        for (j = int'(cs); j < len_b_st; j++) begin
                            if (path_a[i] == path_b[j]) begin
                                dup = 1'b1;
                            end
                        end
                        if (!dup) begin
                            merged_path_q.push_back('{16'(path_a[i]), 1'b0, 1'b0});
                        end
                    end
                    // Then the whole suffix of the second path.
                    for (j = int'(cs); j < len_b_st; j++) begin
                        merged_path_q.push_back('{16'(path_b[j]), 1'b0, 1'b0});
                    end
                    if (merged_path_q.size() > n0) begin
                        r = merged_path_q.pop_back();
                        r.last = 1'b1;
                        merged_path_q.push_back(r);
                    end
                end
                len_a_st = 0;
                len_b_st = 0;
            end
            default: begin
            end
        endcase
    endtask

    // Offer one transaction, wait for its acceptance and record what it should cause.
    task automatic send_txn(input logic [1:0] kind, input logic [15:0] node,
                            input logic [4:0] cf, input logic [5:0] cs,
                            input bit typed, input t_path_node typed_res);
        int n0;
        if (!quiet && $urandom_range(99) < 8) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_kind       <= kind;
        i_node       <= node;
        i_cut_first  <= cf;
        i_cut_second <= cs;
        do @(posedge i_clk); while (o_in_stall);
        n0 = merged_path_q.size();
        predict_crossover(kind, node, cf, cs);
        // Rows with a hand-written result replace whatever was predicted.
        if (typed) begin
            while (merged_path_q.size() > n0) merged_path_q.delete(merged_path_q.size() - 1);
            merged_path_q.push_back(typed_res);
        end
        if (kind != KIND_NONE) items_sent++;
    endtask

    // Stop offering transactions until every expected node has come out or the guard runs out.
    task automatic hold_until_drained(input int guard);
        int waited;
        waited = 0;
        i_in_valid <= 1'b0;
        while (merged_path_q.size() != 0 && waited < guard) begin
            @(posedge i_clk);
            waited++;
        end
    endtask

    function automatic logic [15:0] pick_node();
        return ($urandom_range(1) == 0) ? 16'($urandom_range(7))
                                        : 16'($urandom_range(16'hFFFF));
    endfunction

    function automatic int pick_len(input int lo);
        return ($urandom_range(11) == 0) ? $urandom_range(30, 34) : $urandom_range(lo, 6);
    endfunction

    // Load two paths in random interleaving, with the odd ignored transaction, then merge.
    task automatic run_path_pair(input int na, input int nb, input t_cut_mode mode);
        int         la;
        int         lb;
        int         ka;
        int         kb;
        logic [4:0] cf;
        logic [5:0] cs;
        la = 0;
        lb = 0;
        ka = (na < MAX_LEN) ? na : MAX_LEN;
        kb = (nb < MAX_LEN) ? nb : MAX_LEN;
        while (la < na || lb < nb) begin
            if ($urandom_range(19) == 0) begin
                send_txn(KIND_NONE, 16'($urandom), 5'($urandom), 6'($urandom), 1'b0, NONE_RES);
            end else if (lb >= nb || (la < na && $urandom_range(1) == 0)) begin
                send_txn(KIND_FIRST, pick_node(), 5'($urandom), 6'($urandom), 1'b0, NONE_RES);
                la++;
            end else begin
                send_txn(KIND_SECOND, pick_node(), 5'($urandom), 6'($urandom), 1'b0, NONE_RES);
                lb++;
            end
        end
        case (mode)
            CUT_LEGAL: begin
                cf = 5'($urandom_range(ka - 1));
                cs = 6'($urandom_range(kb));
            end
            CUT_EDGE: begin
                cf = 5'(ka - 1);
                cs = 6'(kb);
            end
            CUT_WIDE: begin
                cf = 5'(ka - 1);
                cs = 6'd0;
            end
            default: begin
                cf = 5'($urandom_range(31));
                cs = 6'($urandom_range(63));
            end
        endcase
        send_txn(KIND_MERGE, 16'($urandom), cf, cs, 1'b0, NONE_RES);
    endtask

    // Result side: check each accepted node and stall at random.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            nodes_seen++;
            if (merged_path_q.size() == 0) begin
                fail_cnt++;
                $display("%0t: unexpected node_out %h last %b error %b, nothing expected",
                         $time, o_node_out, o_last, o_error);
            end else begin
                if (o_node_out !== merged_path_q[0].node) begin
                    fail_cnt++;
                    $display("%0t: node_out expected %h actual %h",
                             $time, merged_path_q[0].node, o_node_out);
                end
                if (o_last !== merged_path_q[0].last) begin
                    fail_cnt++;
                    $display("%0t: last expected %b actual %b",
                             $time, merged_path_q[0].last, o_last);
                end
                if (o_error !== merged_path_q[0].err) begin
                    fail_cnt++;
                    $display("%0t: error expected %b actual %b",
                             $time, merged_path_q[0].err, o_error);
                end
                merged_path_q.delete(0);
            end
        end
        i_out_stall <= !quiet && ($urandom_range(99) < 8);
    end

    // Main sequence: reset, directed table, random paths, drain and verdict.
    initial begin
        bit held;
        held     = 1'b0;
        len_a_st = 0;
        len_b_st = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < DIR_ROWS; r++) begin
            send_txn(dir_tab[r].kind, dir_tab[r].node, dir_tab[r].cf, dir_tab[r].cs,
                     dir_tab[r].typed, dir_tab[r].res);
        end
        hold_until_drained(200000);

        // Full stores first: overflowing loads, then the edge and the widest cuts.
        run_path_pair(34, 33, CUT_EDGE);
        run_path_pair(32, 34, CUT_WIDE);

        while (items_sent < TARGET_ITEMS) begin
            quiet = (items_sent >= 150 && items_sent < 230);
            if ($urandom_range(99) < 85) begin
                run_path_pair(pick_len(1), pick_len(0),
                              ($urandom_range(9) == 0) ? CUT_ANY : CUT_LEGAL);
            end else begin
                run_path_pair($urandom_range(3), $urandom_range(3), CUT_ANY);
            end
            if (!held && items_sent > 200) begin
                hold_until_drained(200000);
                held = 1'b1;
            end
        end
        quiet = 1'b0;

        hold_until_drained(200000);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (merged_path_q.size() != 0) begin
            fail_cnt++;
            $display("%0t: %0d expected nodes never arrived, oldest node %h last %b error %b",
                     $time, merged_path_q.size(), merged_path_q[0].node,
                     merged_path_q[0].last, merged_path_q[0].err);
        end

        $display("Sent %0d load and merge transactions: %0d merges, %0d with bad cuts, %s",
                 items_sent, merges, bad_cuts, $sformatf("%0d loads dropped.", dropped));
        $display("Checked %0d merged nodes with random idling on both sides.", nodes_seen);
        if (fail_cnt == 0) begin
            $display("path_crossover_dedup_merge_top regression: pass");
        end else begin
            $display("path_crossover_dedup_merge_top regression: fail");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #5000000;
        $display("path_crossover_dedup_merge_top regression: fail");
        $finish;
    end

endmodule

// File: filelist.f
rtl/pcdm_pkg.sv
rtl/pcdm_ram.sv
rtl/pcdm_ctrl.sv
rtl/path_crossover_dedup_merge_top.sv
dv/path_crossover_dedup_merge_top_test.sv
